>>> sv/tof_obstacle_avoid_controller_macros.svh
// ----------------------------------------------------------------------------
// tof_obstacle_avoid_controller_macros.svh
// Assertion helpers for the obstacle-avoidance controller. All checks run on
// i_clk and are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TOF_OBSTACLE_AVOID_CONTROLLER_MACROS_SVH
`define TOF_OBSTACLE_AVOID_CONTROLLER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define TOAC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies a delayed consequent
`define TOAC_ASSERT_LAT2(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

`endif

>>> sv/toac_pkg.sv
// ----------------------------------------------------------------------------
// toac_pkg
// Types, constants and codes shared by the obstacle-avoidance controller.
// ----------------------------------------------------------------------------
package toac_pkg;

    localparam int NUM_FRONT    = 3;
    localparam int GROUP_PIXELS = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [7:0]  NEUTRAL        = 8'd127;
    localparam logic [15:0] NO_DISTANCE    = 16'hFFFF;
    localparam logic [7:0]  STATUS_INVALID = 8'hFF;
    localparam logic [7:0]  STATUS_VALID   = 8'h00;

    localparam logic [15:0] DANGER_RESET      = 16'd370;
    localparam logic [15:0] STR_THR_RESET     = 16'd2;
    localparam logic [6:0]  SHIFT_SPEED_RESET = 7'd100;

    typedef enum logic [1:0] {
        ACT_REPORT = 2'd0,
        ACT_PIXEL  = 2'd1,
        ACT_EVAL   = 2'd2,
        ACT_TIMER  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        TURN_NONE = 2'd0,
        TURN_CCW  = 2'd1,
        TURN_CW   = 2'd2
    } t_turn;

    typedef enum logic [1:0] {
        REG_DANGER      = 2'd0,
        REG_STR_THR     = 2'd1,
        REG_SHIFT_SPEED = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]  action;
        logic [2:0]  sensor_id;
        logic [5:0]  pixel_index;
        logic [15:0] distance_mm;
        logic [7:0]  meas_status;
        logic [15:0] echo_strength;
        logic        last_pixel;
    } t_in_item;

    typedef struct packed {
        logic [7:0] lateral_cmd;
        logic [7:0] forward_cmd;
        logic [7:0] rotate_cmd;
        logic       drive_update;
        logic       shift_timer_load;
        logic [1:0] turn_phase;
    } t_out_item;

    typedef struct packed {
        logic [15:0] danger;
        logic [15:0] str_thr;
        logic [6:0]  shift_speed;
    } t_cfg;

    // decoded work for the back end
    typedef struct packed {
        t_action     kind;
        logic [1:0]  idx;      // sensor for reports, group for pixels
        logic [3:0]  rank;
        logic        take;
        logic        commit;
        logic [15:0] range_mm;
        logic [7:0]  status;
        logic [15:0] strength;
    } t_op;

endpackage

>>> sv/toac_front.sv
// ----------------------------------------------------------------------------
// toac_front
// Input side: accepts beats, maps pixels to column groups and ranks, drops
// items that change nothing and queues the rest.
// ----------------------------------------------------------------------------
module toac_front (
    input  toac_pkg::t_in_item i_item,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_q_full,
    output logic               o_push,
    output toac_pkg::t_op      o_op
);
    import toac_pkg::*;

    localparam logic [1:0] GRP_RIGHT  = 2'd0;
    localparam logic [1:0] GRP_MIDDLE = 2'd1;
    localparam logic [1:0] GRP_LEFT   = 2'd2;
    localparam logic [1:0] GRP_NONE   = 2'd3;

    logic [2:0] col;
    logic [1:0] grp;
    logic       low_col;
    logic [3:0] rank;
    logic       take;
    logic       keep;

    assign col = i_item.pixel_index[2:0];

    always_comb begin
        grp     = GRP_NONE;
        low_col = 1'b0;
        case (col)
            3'd7: begin grp = GRP_RIGHT;  low_col = 1'b0; end
            3'd6: begin grp = GRP_RIGHT;  low_col = 1'b1; end
            3'd4: begin grp = GRP_MIDDLE; low_col = 1'b0; end
            3'd3: begin grp = GRP_MIDDLE; low_col = 1'b1; end
            3'd1: begin grp = GRP_LEFT;   low_col = 1'b0; end
            3'd0: begin grp = GRP_LEFT;   low_col = 1'b1; end
            default: begin grp = GRP_NONE; low_col = 1'b0; end
        endcase
    end

    assign rank = {i_item.pixel_index[5:3], low_col};
    assign take = (grp != GRP_NONE) && (i_item.meas_status == STATUS_VALID)
               && ({2'b00, rank} < 6'(GROUP_PIXELS));

    always_comb begin
        keep = 1'b0;
        case (t_action'(i_item.action))
            ACT_REPORT: keep = (i_item.sensor_id < 3'(NUM_FRONT));
            ACT_PIXEL:  keep = (i_item.sensor_id == 3'd0) && (take || i_item.last_pixel);
            ACT_EVAL:   keep = 1'b1;
            ACT_TIMER:  keep = 1'b1;
            default:    keep = 1'b0;
        endcase
    end

    always_comb begin
        o_op.kind     = t_action'(i_item.action);
        o_op.idx      = (t_action'(i_item.action) == ACT_REPORT) ?
                        i_item.sensor_id[1:0] : grp;
        o_op.rank     = rank;
        o_op.take     = take;
        o_op.commit   = i_item.last_pixel;
        o_op.range_mm = i_item.distance_mm;
        o_op.status   = i_item.meas_status;
        o_op.strength = i_item.echo_strength;
    end

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && o_ready && keep;

endmodule

>>> sv/toac_fifo.sv
// ----------------------------------------------------------------------------
// toac_fifo
// Short queue of decoded items between the front and back ends.
// ----------------------------------------------------------------------------
module toac_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  toac_pkg::t_op              i_op,
    input  logic                       i_pop,
    output toac_pkg::t_op              o_op,
    output logic                       o_valid,
    output logic                       o_full,
    output logic [toac_pkg::QUEUE_AW:0] o_count
);
    import toac_pkg::*;

    t_op                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_push;
    logic                do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    assign o_op    = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_count = r_count;

endmodule

>>> sv/toac_back.sv
// ----------------------------------------------------------------------------
// toac_back
// Execution side: holds sensor and group state, runs the avoidance rules and
// the turn sequencer, and registers the result beat.
// ----------------------------------------------------------------------------
module toac_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  toac_pkg::t_cfg      i_cfg,
    input  logic                i_q_valid,
    input  toac_pkg::t_op       i_op,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output toac_pkg::t_out_item o_item
);
    import toac_pkg::*;

    logic [15:0] r_fdist [NUM_FRONT];
    logic [15:0] r_fstr  [NUM_FRONT];
    logic [7:0]  r_fstat [NUM_FRONT];
    logic [15:0] r_gdist [NUM_FRONT];
    logic [7:0]  r_gstr  [NUM_FRONT];
    logic [3:0]  r_grank [NUM_FRONT];
    logic        r_gvalid[NUM_FRONT];

    logic [15:0] n_fdist [NUM_FRONT];
    logic [15:0] n_fstr  [NUM_FRONT];
    logic [7:0]  n_fstat [NUM_FRONT];
    logic [15:0] n_gdist [NUM_FRONT];
    logic [7:0]  n_gstr  [NUM_FRONT];
    logic [3:0]  n_grank [NUM_FRONT];
    logic        n_gvalid[NUM_FRONT];

    t_turn       r_turn;
    t_turn       n_turn;
    logic        r_out_valid;
    t_out_item   r_out;

    logic        is_eval;
    logic [2:0]  blk;       // {right, middle, left}
    logic [7:0]  speed_lo;
    logic [7:0]  speed_hi;
    logic [7:0]  lat;
    logic [7:0]  rot;
    logic        drive;
    logic        load;

    assign is_eval = (i_op.kind == ACT_EVAL);
    assign o_pop   = i_q_valid && (!is_eval || !r_out_valid || i_ready);

    // sensor and group state update
    always_comb begin
        logic better;
        better = 1'b0;
        for (int g = 0; g < NUM_FRONT; g++) begin
            n_fdist[g]  = r_fdist[g];
            n_fstr[g]   = r_fstr[g];
            n_fstat[g]  = r_fstat[g];
            n_gdist[g]  = r_gdist[g];
            n_gstr[g]   = r_gstr[g];
            n_grank[g]  = r_grank[g];
            n_gvalid[g] = r_gvalid[g];
            if (o_pop && i_op.kind == ACT_REPORT && i_op.idx == 2'(g)) begin
                n_fdist[g] = i_op.range_mm;
                n_fstr[g]  = i_op.strength;
                n_fstat[g] = i_op.status;
            end
            if (o_pop && i_op.kind == ACT_PIXEL) begin
                better = !r_gvalid[g] || (i_op.range_mm < r_gdist[g])
                      || (i_op.range_mm == r_gdist[g] && i_op.rank < r_grank[g]);
                if (i_op.take && i_op.idx == 2'(g) && better) begin
                    n_gdist[g]  = i_op.range_mm;
                    n_gstr[g]   = i_op.strength[7:0];
                    n_grank[g]  = i_op.rank;
                    n_gvalid[g] = 1'b1;
                end
                if (i_op.commit) begin
                    n_fdist[g]  = n_gvalid[g] ? n_gdist[g] : NO_DISTANCE;
                    n_fstr[g]   = n_gvalid[g] ? {8'h00, n_gstr[g]} : 16'h0000;
                    n_fstat[g]  = STATUS_VALID;
                    n_gdist[g]  = NO_DISTANCE;
                    n_gstr[g]   = 8'h00;
                    n_grank[g]  = 4'h0;
                    n_gvalid[g] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_FRONT; g++) begin
                r_fdist[g]  <= '0;
                r_fstr[g]   <= '0;
                r_fstat[g]  <= '0;
                r_gdist[g]  <= NO_DISTANCE;
                r_gstr[g]   <= '0;
                r_grank[g]  <= '0;
                r_gvalid[g] <= 1'b0;
            end
        end else begin
            for (int g = 0; g < NUM_FRONT; g++) begin
                r_fdist[g]  <= n_fdist[g];
                r_fstr[g]   <= n_fstr[g];
                r_fstat[g]  <= n_fstat[g];
                r_gdist[g]  <= n_gdist[g];
                r_gstr[g]   <= n_gstr[g];
                r_grank[g]  <= n_grank[g];
                r_gvalid[g] <= n_gvalid[g];
            end
        end
    end

    always_comb begin
        for (int s = 0; s < NUM_FRONT; s++) begin
            blk[2 - s] = (r_fdist[s] < i_cfg.danger) && (r_fstr[s] > i_cfg.str_thr)
                      && (r_fstat[s] != STATUS_INVALID);
        end
    end

    assign speed_lo = NEUTRAL - {1'b0, i_cfg.shift_speed};
    assign speed_hi = NEUTRAL + {1'b0, i_cfg.shift_speed};

    // turn sequencer: next state
    always_comb begin
        n_turn = r_turn;
        if (o_pop && i_op.kind == ACT_TIMER) begin
            if (r_turn == TURN_CCW) begin
                n_turn = TURN_CW;
            end
        end else if (o_pop && is_eval) begin
            case (blk)
                3'b111: begin
                    if (r_turn == TURN_NONE) begin
                        n_turn = TURN_CCW;
                    end
                end
                3'b100:  n_turn = TURN_NONE;
                3'b001:  n_turn = TURN_NONE;
                default: n_turn = r_turn;
            endcase
        end
    end

    // rule outputs
    always_comb begin
        lat   = NEUTRAL;
        rot   = NEUTRAL;
        drive = 1'b0;
        load  = 1'b0;
        case (blk)
            3'b111: begin
                if (r_turn == TURN_NONE) begin
                    rot   = speed_lo;
                    drive = 1'b1;
                end else if (r_turn == TURN_CW) begin
                    rot   = speed_hi;
                    drive = 1'b1;
                end
            end
            3'b110: begin lat = speed_lo; drive = 1'b1; end
            3'b011: begin lat = speed_hi; drive = 1'b1; end
            3'b101: begin lat = speed_lo; drive = 1'b1; end
            3'b100: begin lat = speed_lo; drive = 1'b1; load = 1'b1; end
            3'b010: begin lat = speed_lo; drive = 1'b1; end
            3'b001: begin lat = speed_hi; drive = 1'b1; load = 1'b1; end
            default: begin
                lat   = NEUTRAL;
                rot   = NEUTRAL;
                drive = 1'b0;
                load  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn      <= TURN_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_turn <= n_turn;
            if (o_pop && is_eval) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result until the beat is taken
    always_ff @(posedge i_clk) begin
        if (o_pop && is_eval) begin
            r_out.lateral_cmd      <= lat;
            r_out.forward_cmd      <= NEUTRAL;
            r_out.rotate_cmd       <= rot;
            r_out.drive_update     <= drive;
            r_out.shift_timer_load <= load;
            r_out.turn_phase       <= n_turn;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

>>> sv/tof_obstacle_avoid_controller.sv
// Result path: an evaluate beat is written into the queue and its result is then
// registered in the back end; other items produce no result.
// Throughput: one item per cycle, set by the back end taking one queued item per
// cycle when no evaluate result is held; the four-entry queue absorbs output stalls.
// Reset: synchronous active-low i_rst_n clears sensors, groups, turn state and
// the queue, and restores the configuration registers to their defaults.
// ----------------------------------------------------------------------------
// tof_obstacle_avoid_controller
// Front range-sensor fusion and obstacle-avoidance command generator with an
// APB-style configuration port.
// ----------------------------------------------------------------------------
`include "tof_obstacle_avoid_controller_macros.svh"

module tof_obstacle_avoid_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  toac_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output toac_pkg::t_out_item o_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import toac_pkg::*;

    logic [15:0]       r_danger;
    logic [15:0]       r_str_thr;
    logic [6:0]        r_shift_speed;
    t_cfg              cfg;
    logic              cfg_wr;

    logic              q_full;
    logic              q_push;
    t_op               q_in;
    logic              q_pop;
    t_op               q_out;
    logic              q_valid;
    logic [QUEUE_AW:0] q_count;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_danger      <= DANGER_RESET;
            r_str_thr     <= STR_THR_RESET;
            r_shift_speed <= SHIFT_SPEED_RESET;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_DANGER:      r_danger      <= pwdata[15:0];
                REG_STR_THR:     r_str_thr     <= pwdata[15:0];
                REG_SHIFT_SPEED: r_shift_speed <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_DANGER:      prdata = {16'h0000, r_danger};
            REG_STR_THR:     prdata = {16'h0000, r_str_thr};
            REG_SHIFT_SPEED: prdata = {25'h0, r_shift_speed};
            default:         prdata = 32'h0;
        endcase
    end

    assign cfg.danger      = r_danger;
    assign cfg.str_thr     = r_str_thr;
    assign cfg.shift_speed = r_shift_speed;

    toac_front u_front (
        .i_item   (i_item),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_op     (q_in)
    );

    toac_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in),
        .i_pop   (q_pop),
        .o_op    (q_out),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_count (q_count)
    );

    toac_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_op      (q_out),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item)
    );

    `TOAC_ASSERT_LAT2(a_eval_latency, i_valid && o_ready && i_item.action == ACT_EVAL && q_count == '0 && (!o_valid || i_ready), o_valid, "evaluate beat did not reach the output in two cycles")
    `TOAC_ASSERT_IMP(a_load_only_on_drive, o_valid && o_item.shift_timer_load, o_item.drive_update && o_item.turn_phase == TURN_NONE, "shift timer load without drive or with turn in progress")
    `TOAC_ASSERT_IMP(a_idle_cmds_neutral, o_valid && !o_item.drive_update, o_item.lateral_cmd == NEUTRAL && o_item.rotate_cmd == NEUTRAL, "commands not neutral without a drive update")

endmodule

>>> sim/toac_checker.sv
// ----------------------------------------------------------------------------
// toac_checker
// Watches the item, command and register ports of the obstacle-avoidance
// controller. It keeps its own copy of the sensor, group and turn state, works
// out the command that each evaluate beat should give, and compares every
// command beat field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module toac_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  toac_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  toac_pkg::t_out_item i_out_item,
    input  logic                i_psel,
    input  logic                i_penable,
    input  logic                i_pwrite,
    input  logic                i_pready,
    input  logic [3:0]          i_paddr,
    input  logic [31:0]         i_pwdata,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_checked
);
    import toac_pkg::*;

    logic [15:0] cfg_danger;
    logic [15:0] cfg_thr;
    logic [6:0]  cfg_speed;

    logic [15:0] front_dist [NUM_FRONT];
    logic [15:0] front_str  [NUM_FRONT];
    logic [7:0]  front_stat [NUM_FRONT];

    logic [15:0] grp_dist [NUM_FRONT];
    logic [7:0]  grp_stat [NUM_FRONT];
    logic [7:0]  grp_str  [NUM_FRONT];
    logic [5:0]  grp_pix  [NUM_FRONT];
    bit          grp_hit  [NUM_FRONT];

    t_turn       turn;
    t_out_item   cmd_q [$];

    function automatic void clear_groups();
        for (int g = 0; g < NUM_FRONT; g++) begin
            grp_dist[g] = NO_DISTANCE;
            grp_stat[g] = '0;
            grp_str[g]  = '0;
            grp_pix[g]  = '0;
            grp_hit[g]  = 1'b0;
        end
    endfunction

    function automatic void reset_model();
        cfg_danger = DANGER_RESET;
        cfg_thr    = STR_THR_RESET;
        cfg_speed  = SHIFT_SPEED_RESET;
        for (int s = 0; s < NUM_FRONT; s++) begin
            front_dist[s] = '0;
            front_str[s]  = '0;
            front_stat[s] = '0;
        end
        clear_groups();
        turn = TURN_NONE;
    endfunction

    // 0 right, 1 middle, 2 left, 3 for the unused columns
    function automatic int col_group(input logic [2:0] col);
        case (col)
            3'd6, 3'd7: return 0;
            3'd3, 3'd4: return 1;
            3'd0, 3'd1: return 2;
            default:    return 3;
        endcase
    endfunction

    // earlier row wins, then the upper column of the pair
    function automatic int pixel_rank(input logic [5:0] pix);
        int hi_col;
        case (col_group(pix[2:0]))
            0:       hi_col = 7;
            1:       hi_col = 4;
            2:       hi_col = 1;
            default: hi_col = 0;
        endcase
        return int'(pix[5:3]) * 2 + ((int'(pix[2:0]) == hi_col) ? 0 : 1);
    endfunction

    function automatic void take_pixel(input t_in_item it);
        int g;
        int rank;
        bit take;
        g    = col_group(it.pixel_index[2:0]);
        rank = pixel_rank(it.pixel_index);
        if (g > 2 || it.meas_status != STATUS_VALID || rank >= GROUP_PIXELS)
            return;
        take = !grp_hit[g] || it.distance_mm < grp_dist[g] ||
               (it.distance_mm == grp_dist[g] && rank < pixel_rank(grp_pix[g]));
        if (take) begin
            grp_hit[g]  = 1'b1;
            grp_dist[g] = it.distance_mm;
            grp_stat[g] = it.meas_status;
            grp_str[g]  = it.echo_strength[7:0];
            grp_pix[g]  = it.pixel_index;
        end
    endfunction

    function automatic void commit_groups();
        for (int g = 0; g < NUM_FRONT; g++) begin
            front_dist[g] = grp_hit[g] ? grp_dist[g] : NO_DISTANCE;
            front_stat[g] = grp_hit[g] ? grp_stat[g] : 8'd0;
            front_str[g]  = grp_hit[g] ? {8'd0, grp_str[g]} : 16'd0;
        end
        clear_groups();
    endfunction

    function automatic bit is_blocked(input int s);
        return front_dist[s] < cfg_danger && front_str[s] > cfg_thr &&
               front_stat[s] != STATUS_INVALID;
    endfunction

    function automatic t_out_item avoidance_cmd();
        t_out_item cmd;
        logic [7:0] left_shift;
        logic [7:0] right_shift;
        bit r, m, l;
        cmd.lateral_cmd      = NEUTRAL;
        cmd.forward_cmd      = NEUTRAL;
        cmd.rotate_cmd       = NEUTRAL;
        cmd.drive_update     = 1'b0;
        cmd.shift_timer_load = 1'b0;
        right_shift = NEUTRAL - {1'b0, cfg_speed};
        left_shift  = NEUTRAL + {1'b0, cfg_speed};
        r = is_blocked(0);
        m = is_blocked(1);
        l = is_blocked(2);
        if (r && m && l) begin
            // turn away counterclockwise first; hold still until the timer flips it
            if (turn == TURN_NONE) begin
                cmd.rotate_cmd   = right_shift;
                cmd.drive_update = 1'b1;
                turn             = TURN_CCW;
            end else if (turn == TURN_CW) begin
                cmd.rotate_cmd   = left_shift;
                cmd.drive_update = 1'b1;
            end
        end else if ((r && m) || (r && l)) begin
            cmd.lateral_cmd  = right_shift;
            cmd.drive_update = 1'b1;
        end else if (m && l) begin
            cmd.lateral_cmd  = left_shift;
            cmd.drive_update = 1'b1;
        end else if (r) begin
            cmd.lateral_cmd      = right_shift;
            cmd.drive_update     = 1'b1;
            cmd.shift_timer_load = 1'b1;
            turn                 = TURN_NONE;
        end else if (m) begin
            cmd.lateral_cmd  = right_shift;
            cmd.drive_update = 1'b1;
        end else if (l) begin
            cmd.lateral_cmd      = left_shift;
            cmd.drive_update     = 1'b1;
            cmd.shift_timer_load = 1'b1;
            turn                 = TURN_NONE;
        end
        cmd.turn_phase = turn;
        return cmd;
    endfunction

    function automatic void predict_beat(input t_in_item it);
        case (t_action'(it.action))
            ACT_REPORT: begin
                if (it.sensor_id < NUM_FRONT) begin
                    front_dist[it.sensor_id] = it.distance_mm;
                    front_stat[it.sensor_id] = it.meas_status;
                    front_str[it.sensor_id]  = it.echo_strength;
                end
            end
            ACT_PIXEL: begin
                // only module 0 feeds the groups, its last-pixel mark included
                if (it.sensor_id == 3'd0) begin
                    take_pixel(it);
                    if (it.last_pixel)
                        commit_groups();
                end
            end
            ACT_TIMER: begin
                if (turn == TURN_CCW)
                    turn = TURN_CW;
            end
            default: cmd_q.push_back(avoidance_cmd());
        endcase
    endfunction

    function automatic void write_reg(input logic [3:0] addr, input logic [31:0] data);
        if (addr[1:0] != 2'b00)
            return;
        case (t_reg_idx'(addr[3:2]))
            REG_DANGER:      cfg_danger = data[15:0];
            REG_STR_THR:     cfg_thr    = data[15:0];
            REG_SHIFT_SPEED: cfg_speed  = data[6:0];
            default: ;
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("%0t: command mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0d, expected %0d", name, got, want));
    endtask

    task automatic compare_cmd(input t_out_item got);
        t_out_item want;
        if (cmd_q.size() == 0) begin
            report_error($sformatf("command beat %h with none pending", got));
            return;
        end
        want = cmd_q.pop_front();
        check_field("lateral_cmd", got.lateral_cmd, want.lateral_cmd);
        check_field("forward_cmd", got.forward_cmd, want.forward_cmd);
        check_field("rotate_cmd", got.rotate_cmd, want.rotate_cmd);
        check_field("drive_update", 8'(got.drive_update), 8'(want.drive_update));
        check_field("shift_timer_load", 8'(got.shift_timer_load),
                    8'(want.shift_timer_load));
        check_field("turn_phase", 8'(got.turn_phase), 8'(want.turn_phase));
        o_checked++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            cmd_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready)
                write_reg(i_paddr, i_pwdata);
            // push before pop so a command leaving in the same cycle as its beat would still find its entry
            if (i_in_valid && i_in_ready)
                predict_beat(i_in_item);
            if (i_out_valid && i_out_ready)
                compare_cmd(i_out_item);
        end
        o_pending = cmd_q.size();
    end

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench top for the obstacle-avoidance controller. Drives sensor reports,
// multizone frames, evaluate and timer beats in random bursts, stalls the
// command side on its own pattern, and steps the registers through several
// settings. The checker beside the block does the predicting.
// ----------------------------------------------------------------------------
module tb;
    import toac_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_BEATS  = 200;
    localparam int NUM_PHASES   = 6;
    localparam int HOLD_CYCLES  = 100;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_item;
    logic        o_valid;
    logic        i_ready;
    t_out_item   o_item;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int n_fail;
    int n_pending;
    int n_checked;

    int  cur_danger = int'(DANGER_RESET);
    int  cur_thr    = int'(STR_THR_RESET);
    int  burst_left = 0;
    int  n_work     = 0;
    int  n_beats    = 0;
    int  n_phases   = 0;
    bit  hold_req   = 1'b0;

    tof_obstacle_avoid_controller dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_item  (o_item),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    toac_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_ready   (o_ready),
        .i_in_item    (i_item),
        .i_out_valid  (o_valid),
        .i_out_ready  (i_ready),
        .i_out_item   (o_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (n_fail),
        .o_pending    (n_pending),
        .o_checked    (n_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_in_item make_item(input t_action act, input int id, input int pix,
                                           input int mm, input int stat, input int str,
                                           input bit last);
        t_in_item it;
        it.action        = act;
        it.sensor_id     = 3'(id);
        it.pixel_index   = 6'(pix);
        it.distance_mm   = 16'(mm);
        it.meas_status   = 8'(stat);
        it.echo_strength = 16'(str);
        it.last_pixel    = last;
        return it;
    endfunction

    function automatic t_in_item rand_item(input t_action act);
        return make_item(act, $urandom_range(0, 7), $urandom_range(0, 63),
                         $urandom_range(0, 65535), $urandom_range(0, 255),
                         $urandom_range(0, 65535), 1'($urandom_range(0, 1)));
    endfunction

    function automatic int near_dist();
        return (cur_danger == 0) ? 0 : $urandom_range(0, cur_danger - 1);
    endfunction

    function automatic int strong_str();
        return (cur_thr >= 65535) ? 65535 : $urandom_range(cur_thr + 1, 65535);
    endfunction

    function automatic t_in_item sensor_report(input int id, input bit blk);
        int mm;
        int stat;
        int str;
        mm   = near_dist();
        stat = 0;
        str  = strong_str();
        if (blk) begin
            if ($urandom_range(0, 3) == 0)
                stat = $urandom_range(0, 254);
        end else begin
            case ($urandom_range(0, 3))
                0: mm   = $urandom_range(cur_danger, 65535);
                1: stat = int'(STATUS_INVALID);
                2: str  = $urandom_range(0, cur_thr);
                default: begin
                    mm   = $urandom_range(0, 65535);
                    stat = $urandom_range(0, 255);
                    str  = $urandom_range(0, 65535);
                end
            endcase
        end
        return make_item(ACT_REPORT, id, $urandom_range(0, 63), mm, stat, str,
                         1'($urandom_range(0, 1)));
    endfunction

    function automatic t_in_item frame_pixel(input int idx, input bit last);
        int mm;
        int stat;
        case ($urandom_range(0, 3))
            0: mm = near_dist();
            1: mm = $urandom_range(0, 3) * 64;   // few values, so ties happen
            2: mm = $urandom_range(0, 65535);
            default: mm = $urandom_range(cur_danger, 65535);
        endcase
        stat = int'(STATUS_VALID);
        if ($urandom_range(0, 4) == 0)
            stat = $urandom_range(0, 1) ? int'(STATUS_INVALID) : $urandom_range(0, 255);
        return make_item(ACT_PIXEL, 0, idx, mm, stat, $urandom_range(0, 65535), last);
    endfunction

    // present one beat, lowering valid only when a burst ends
    task automatic send_beat(input t_in_item it);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        n_beats++;
        if (!((it.action == ACT_REPORT && it.sensor_id >= NUM_FRONT) ||
              (it.action == ACT_PIXEL && it.sensor_id != 3'd0)))
            n_work++;
    endtask

    // stop offering and let every command and any trailing non-command beat drain
    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        wait (n_pending == 0);
        @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int danger, input int thr, input int speed);
        apb_write(REG_DANGER, ($urandom() & 32'hFFFF_0000) | 32'(danger));
        apb_write(REG_STR_THR, ($urandom() & 32'hFFFF_0000) | 32'(thr));
        apb_write(REG_SHIFT_SPEED, ($urandom() & 32'hFFFF_FF80) | 32'(speed));
        cur_danger = danger;
        cur_thr    = thr;
        n_phases++;
    endtask

    task automatic run_directed();
        t_in_item ev;
        int       ok;
        int       bad;
        ok  = int'(STATUS_VALID);
        bad = int'(STATUS_INVALID);
        ev  = make_item(ACT_EVAL, 0, 0, 0, 0, 0, 1'b0);
        send_beat(ev);                                              // nothing blocked
        send_beat(make_item(ACT_REPORT, 0, 0, 0, ok, 65535, 1'b0));
        send_beat(ev);                                              // right only
        send_beat(make_item(ACT_REPORT, 1, 0, 0, ok, 65535, 1'b0));
        send_beat(ev);                                              // right and middle
        send_beat(make_item(ACT_REPORT, 0, 0, 0, bad, 65535, 1'b0));
        send_beat(ev);                                              // middle only
        send_beat(make_item(ACT_REPORT, 2, 0, 0, ok, 65535, 1'b0));
        send_beat(ev);                                              // middle and left
        send_beat(make_item(ACT_REPORT, 1, 0, 65535, ok, 65535, 1'b0));
        send_beat(ev);                                              // left only
        send_beat(make_item(ACT_REPORT, 0, 0, 0, ok, 65535, 1'b0));
        send_beat(ev);                                              // right and left
        send_beat(make_item(ACT_REPORT, 1, 0, 0, ok, 65535, 1'b0));
        send_beat(ev);                                              // all: start turn
        send_beat(ev);                                              // all while turning
        send_beat(make_item(ACT_TIMER, 7, 63, 65535, bad, 65535, 1'b1));
        send_beat(ev);                                              // turning clockwise
        send_beat(make_item(ACT_TIMER, 0, 0, 0, 0, 0, 1'b0));       // no effect now
        send_beat(make_item(ACT_REPORT, 7, 63, 0, 0, 65535, 1'b1)); // unknown sensor
        send_beat(make_item(ACT_PIXEL, 5, 63, 0, 0, 65535, 1'b1));  // other module
        send_beat(make_item(ACT_PIXEL, 0, 0, 0, ok, 65535, 1'b0));
        send_beat(make_item(ACT_PIXEL, 0, 2, 0, ok, 65535, 1'b0));
        send_beat(make_item(ACT_PIXEL, 0, 63, 65535, bad, 65535, 1'b1));
        send_beat(ev);
    endtask

    task automatic send_frame();
        int  n;
        bit  full;
        full = ($urandom_range(0, 7) == 0);
        n    = full ? 64 : $urandom_range(1, 12);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 15) == 0)
                send_beat(make_item(ACT_PIXEL, $urandom_range(1, 7), $urandom_range(0, 63),
                                    $urandom_range(0, 65535), $urandom_range(0, 255),
                                    $urandom_range(0, 65535), 1'($urandom_range(0, 1))));
            send_beat(frame_pixel(full ? i : $urandom_range(0, 63), i == n - 1));
        end
        send_beat(rand_item(ACT_EVAL));
    endtask

    task automatic send_turn();
        for (int s = 0; s < NUM_FRONT; s++)
            send_beat(sensor_report(s, 1'b1));
        send_beat(rand_item(ACT_EVAL));
        send_beat(rand_item(ACT_EVAL));
        send_beat(rand_item(ACT_TIMER));
        send_beat(rand_item(ACT_EVAL));
        send_beat(sensor_report($urandom_range(0, 2), 1'($urandom_range(0, 1))));
        send_beat(rand_item(ACT_EVAL));
    endtask

    task automatic send_sequence();
        int k;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                k = $urandom_range(1, 3);
                repeat (k)
                    send_beat(sensor_report(($urandom_range(0, 9) == 0) ? $urandom_range(3, 7)
                                                                       : $urandom_range(0, 2),
                                            1'($urandom_range(0, 1))));
                send_beat(rand_item(ACT_EVAL));
            end
            3, 4, 5: send_frame();
            6:       send_turn();
            7: begin
                send_beat(rand_item(ACT_TIMER));
                send_beat(rand_item(ACT_EVAL));
            end
            default: send_beat(rand_item(t_action'($urandom_range(0, 3))));
        endcase
    endtask

    // back-pressure from the command side, with a long hold-off on request
    initial begin
        int mode;
        int left;
        int tick;
        mode = 0;
        left = 0;
        tick = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(10, 80);
                end
                left--;
                tick++;
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom_range(0, 1));
                    2:       i_ready <= (tick % 4 == 0);
                    default: i_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable))
                idle = 0;
            else
                idle++;
        end
        $display("No progress for %0d cycles, %0d commands still pending", idle, n_pending);
        $display("[tof_obstacle_avoid_controller] ERROR");
        $finish;
    end

    initial begin
        int  target;
        bit  pressed;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0:       set_config(65535, 0, 127);
                1:       set_config(0, 65535, 0);
                default: set_config($urandom_range(100, 3000), $urandom_range(0, 200),
                                    $urandom_range(0, 127));
            endcase
            target  = n_work + PHASE_BEATS;
            pressed = 1'b0;
            while (n_work < target) begin
                if (!pressed && n_work >= target - PHASE_BEATS / 2) begin
                    // stall the command side long enough to back up the input
                    hold_req = 1'b1;
                    repeat (12) send_beat(rand_item(ACT_EVAL));
                    drain();
                    pressed = 1'b1;
                end
                send_sequence();
            end
        end

        drain();
        $display("Sent %0d beats (%0d doing work) over %0d register settings plus reset values;",
                 n_beats, n_work, n_phases);
        $display("checked %0d commands, %0d still pending.", n_checked, n_pending);
        if (n_fail == 0 && n_pending == 0)
            $display("[tof_obstacle_avoid_controller] OK");
        else
            $display("[tof_obstacle_avoid_controller] ERROR");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/toac_pkg.sv
sv/toac_front.sv
sv/toac_fifo.sv
sv/toac_back.sv
sv/tof_obstacle_avoid_controller.sv
sim/toac_checker.sv
sim/tb.sv
